[hdl/rbpm_pkg.sv]
// Shared types, constants and helper functions of the rigid body point mover.
package rbpm_pkg;

  localparam int NUM_POINTS   = 256;
  localparam int CORDIC_STEPS = 16;
  localparam int MEM_DEPTH    = (NUM_POINTS < 256) ? NUM_POINTS : 256;
  localparam int ADDR_W       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int RED_STEPS    = 6;
  localparam int RED_W        = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;

  localparam logic signed [32:0] TWO_PI_Q24  = 33'sd105414357;
  localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [17:0] ONE_Q16     = 18'sd65536;

  // Configuration register indexes.
  localparam logic [1:0] REG_INV_DT = 2'd0;
  localparam logic [1:0] REG_INIT_X = 2'd1;
  localparam logic [1:0] REG_INIT_Y = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PATH  = 2'd1,
    ACT_MOVE  = 2'd2,
    ACT_SPARE = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED, ST_FOLD, ST_CORD, ST_ROUND,
    ST_RD, ST_MA, ST_MB, ST_MC, ST_SPX, ST_SPY, ST_SQ, ST_EMIT
  } bk_state_e;

  typedef struct packed {
    action_e            op;
    logic [7:0]         index;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] angle;
    logic               first;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Arctangent of 2^-i in Q8.24.
  function automatic logic [23:0] atan_q24(input logic [4:0] i);
    logic [23:0] v;
    unique case (i)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // Applies the sign to a speed magnitude and saturates to 32 bits.
  function automatic logic signed [31:0] sat_speed(input logic [49:0] q, input logic neg);
    logic signed [31:0] v;
    if (neg) begin
      if (q >= 50'h0_8000_0000) v = 32'sh8000_0000;
      else v = 32'sd0 - $signed({1'b0, q[30:0]});
    end else begin
      if (q > 50'h0_7FFF_FFFF) v = 32'sh7FFF_FFFF;
      else v = $signed({1'b0, q[30:0]});
    end
    return v;
  endfunction

endpackage

[hdl/rbpm_front.sv]
// Front end: accepts requests, drops meaningless ones and queues the rest.
module rbpm_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         point_index_i,
  input  logic signed [31:0] load_x_i,
  input  logic signed [31:0] load_y_i,
  input  logic signed [31:0] path_x_i,
  input  logic signed [31:0] path_y_i,
  input  logic signed [31:0] path_angle_i,
  input  logic               first_sample_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output rbpm_pkg::item_t    q_item_o
);

  logic keep;
  logic idx_ok;

  assign idx_ok = {24'd0, point_index_i} < 32'(rbpm_pkg::NUM_POINTS);

  always_comb begin
    q_item_o.op    = rbpm_pkg::ACT_LOAD;
    q_item_o.index = point_index_i;
    q_item_o.x     = load_x_i;
    q_item_o.y     = load_y_i;
    q_item_o.angle = path_angle_i;
    q_item_o.first = first_sample_i;
    keep           = 1'b0;
    unique case (action_i)
      rbpm_pkg::ACT_LOAD: begin
        keep = idx_ok;
      end
      rbpm_pkg::ACT_PATH: begin
        q_item_o.op = rbpm_pkg::ACT_PATH;
        q_item_o.x  = path_x_i;
        q_item_o.y  = path_y_i;
        keep        = 1'b1;
      end
      rbpm_pkg::ACT_MOVE: begin
        q_item_o.op = rbpm_pkg::ACT_MOVE;
        keep        = idx_ok;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

[hdl/rbpm_queue.sv]
// Small queue between the front end and the execution back end.
module rbpm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rbpm_pkg::item_t       item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output rbpm_pkg::queue_head_t head_o
);

  rbpm_pkg::item_t entry_q [rbpm_pkg::QUEUE_DEPTH];
  logic [rbpm_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rbpm_pkg::QPTR_W:0]   count_q, count_d;
  logic                        do_pop;

  assign do_pop = pop_i && (count_q != '0);
  assign full_o = count_q == (rbpm_pkg::QPTR_W + 1)'(rbpm_pkg::QUEUE_DEPTH);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (rbpm_pkg::QPTR_W + 1)'(push_i) - (rbpm_pkg::QPTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= item_i;
  end

  assign head_o.valid = count_q != '0;
  assign head_o.item  = entry_q[rd_ptr_q];

endmodule

[hdl/rbpm_back.sv]
// Back end: point store, trajectory CORDIC and the point update datapath.
module rbpm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rbpm_pkg::queue_head_t head_i,
  output logic                  pop_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            moved_index_o,
  output logic signed [31:0]    moved_x_o,
  output logic signed [31:0]    moved_y_o,
  output logic signed [31:0]    speed_x_o,
  output logic signed [31:0]    speed_y_o
);

  localparam int RED_W_L = rbpm_pkg::RED_W;
  localparam logic [32:0] TWO_PI_U = 33'(rbpm_pkg::TWO_PI_Q24);

  rbpm_pkg::bk_state_e state_q, state_d;
  rbpm_pkg::item_t     it;

  // Architectural state.
  logic [31:0]        inv_dt_q;
  logic signed [31:0] init_x_q, init_y_q;
  logic signed [31:0] center_x_q, center_y_q, pivot_x_q, pivot_y_q;
  logic signed [31:0] shift_x_q, shift_y_q, last_x_q, last_y_q, last_a_q;
  logic signed [17:0] cos_q, sin_q;
  logic               motion_q;

  // Working registers.
  logic [32:0]        mag_q;
  logic               neg_q, flip_q;
  logic [RED_W_L-1:0] red_k_q;
  logic signed [31:0] r_q;
  logic signed [32:0] cx_q, cy_q;
  logic [rbpm_pkg::STEP_W-1:0] i_q;
  logic [7:0]         idx_q;
  logic signed [31:0] ox_q, oy_q, nx_q, ny_q, spx_q, spy_q;
  logic signed [32:0] rx_q, ry_q;
  logic signed [50:0] p1_q, p2_q;
  logic [48:0]        hi_q;
  logic [47:0]        lo_q;

  // Point store.
  logic signed [31:0] mem_x [rbpm_pkg::MEM_DEPTH];
  logic signed [31:0] mem_y [rbpm_pkg::MEM_DEPTH];
  logic               mem_we, mem_re;
  logic [rbpm_pkg::ADDR_W-1:0] mem_wa;
  logic signed [31:0] mem_wx, mem_wy;

  // Output register.
  logic               out_valid_q;
  logic               out_load;

  // Combinational helpers.
  logic signed [32:0] ang_d;
  logic [32:0]        red_cmp;
  logic signed [31:0] r_fold;
  logic               flip_fold;
  logic signed [32:0] xs, ys;
  logic signed [31:0] atan_v;
  logic signed [32:0] x_rnd, y_rnd;
  logic signed [51:0] rot_sum;
  logic signed [31:0] rot_term;
  logic signed [32:0] dif;
  logic [32:0]        dmag;
  logic [49:0]        qmag;
  logic signed [31:0] sp_val;
  logic signed [31:0] nshift_x, nshift_y;

  assign it = head_i.item;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbpm_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          priority if (it.op == rbpm_pkg::ACT_PATH && !it.first) state_d = rbpm_pkg::ST_RED;
          else if (it.op == rbpm_pkg::ACT_MOVE && motion_q) state_d = rbpm_pkg::ST_RD;
          else state_d = rbpm_pkg::ST_IDLE;
        end
      end
      rbpm_pkg::ST_RED:   if (red_k_q == '0) state_d = rbpm_pkg::ST_FOLD;
      rbpm_pkg::ST_FOLD:  state_d = rbpm_pkg::ST_CORD;
      rbpm_pkg::ST_CORD: begin
        if (i_q == rbpm_pkg::STEP_W'(rbpm_pkg::CORDIC_STEPS - 1)) state_d = rbpm_pkg::ST_ROUND;
      end
      rbpm_pkg::ST_ROUND: state_d = rbpm_pkg::ST_IDLE;
      rbpm_pkg::ST_RD:    state_d = rbpm_pkg::ST_MA;
      rbpm_pkg::ST_MA:    state_d = rbpm_pkg::ST_MB;
      rbpm_pkg::ST_MB:    state_d = rbpm_pkg::ST_MC;
      rbpm_pkg::ST_MC:    state_d = rbpm_pkg::ST_SPX;
      rbpm_pkg::ST_SPX:   state_d = rbpm_pkg::ST_SPY;
      rbpm_pkg::ST_SPY:   state_d = rbpm_pkg::ST_SQ;
      rbpm_pkg::ST_SQ:    state_d = rbpm_pkg::ST_EMIT;
      rbpm_pkg::ST_EMIT:  if (!out_valid_q || out_ready_i) state_d = rbpm_pkg::ST_IDLE;
      default:            state_d = rbpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wa   = it.index[rbpm_pkg::ADDR_W-1:0];
    mem_wx   = it.x;
    mem_wy   = it.y;
    out_load = 1'b0;
    unique case (state_q)
      rbpm_pkg::ST_IDLE: begin
        pop_o  = head_i.valid;
        mem_we = head_i.valid && it.op == rbpm_pkg::ACT_LOAD;
        mem_re = head_i.valid && it.op == rbpm_pkg::ACT_MOVE && motion_q;
      end
      rbpm_pkg::ST_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
        mem_we   = out_load;
        mem_wa   = idx_q[rbpm_pkg::ADDR_W-1:0];
        mem_wx   = nx_q;
        mem_wy   = ny_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[mem_wa] <= mem_wx;
      mem_y[mem_wa] <= mem_wy;
    end
    if (mem_re) begin
      ox_q <= mem_x[it.index[rbpm_pkg::ADDR_W-1:0]];
      oy_q <= mem_y[it.index[rbpm_pkg::ADDR_W-1:0]];
    end
  end

  // Trajectory arithmetic.
  always_comb begin
    nshift_x = it.x - last_x_q;
    nshift_y = it.y - last_y_q;
    ang_d    = {it.angle[31], it.angle} - {last_a_q[31], last_a_q};
    red_cmp  = 33'(TWO_PI_U << red_k_q);
    r_fold   = neg_q ? 32'sd0 - $signed({1'b0, mag_q[30:0]}) : $signed({1'b0, mag_q[30:0]});
    if (r_fold > rbpm_pkg::PI_Q24) r_fold = r_fold - 32'(rbpm_pkg::TWO_PI_Q24);
    if (r_fold < -rbpm_pkg::PI_Q24) r_fold = r_fold + 32'(rbpm_pkg::TWO_PI_Q24);
    flip_fold = 1'b0;
    if (r_fold > rbpm_pkg::HALF_PI_Q24) begin
      r_fold    = r_fold - rbpm_pkg::PI_Q24;
      flip_fold = 1'b1;
    end else if (r_fold < -rbpm_pkg::HALF_PI_Q24) begin
      r_fold    = r_fold + rbpm_pkg::PI_Q24;
      flip_fold = 1'b1;
    end
    xs     = cx_q >>> i_q;
    ys     = cy_q >>> i_q;
    atan_v = $signed({8'd0, rbpm_pkg::atan_q24(5'(i_q))});
    x_rnd  = (cx_q + 33'sd8192) >>> 14;
    y_rnd  = (cy_q + 33'sd8192) >>> 14;
  end

  // Update arithmetic.
  always_comb begin
    if (state_q == rbpm_pkg::ST_MB) rot_sum = {p1_q[50], p1_q} - {p2_q[50], p2_q} + 52'sd32768;
    else rot_sum = {p1_q[50], p1_q} + {p2_q[50], p2_q} + 52'sd32768;
    rot_term = rot_sum[47:16];
    if (state_q == rbpm_pkg::ST_SPX) dif = {nx_q[31], nx_q} - {ox_q[31], ox_q};
    else dif = {ny_q[31], ny_q} - {oy_q[31], oy_q};
    dmag   = dif[32] ? 33'(-dif) : 33'(dif);
    qmag   = 50'(hi_q) + ((50'(lo_q) + 50'h8000) >> 16);
    sp_val = rbpm_pkg::sat_speed(qmag, neg_q);
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rbpm_pkg::ST_IDLE: begin
        mag_q   <= ang_d[32] ? 33'(-ang_d) : 33'(ang_d);
        neg_q   <= ang_d[32];
        red_k_q <= RED_W_L'(rbpm_pkg::RED_STEPS - 1);
        idx_q   <= it.index;
      end
      rbpm_pkg::ST_RED: begin
        if (mag_q >= red_cmp) mag_q <= mag_q - red_cmp;
        red_k_q <= red_k_q - 1'b1;
      end
      rbpm_pkg::ST_FOLD: begin
        r_q    <= r_fold;
        flip_q <= flip_fold;
        cx_q   <= rbpm_pkg::GAIN_Q30;
        cy_q   <= '0;
        i_q    <= '0;
      end
      rbpm_pkg::ST_CORD: begin
        if (r_q >= 0) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          r_q  <= r_q - atan_v;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          r_q  <= r_q + atan_v;
        end
        i_q <= i_q + 1'b1;
      end
      rbpm_pkg::ST_RD: begin
        rx_q <= {ox_q[31], ox_q} - {pivot_x_q[31], pivot_x_q};
        ry_q <= {oy_q[31], oy_q} - {pivot_y_q[31], pivot_y_q};
      end
      rbpm_pkg::ST_MA: begin
        p1_q <= 51'(cos_q * rx_q);
        p2_q <= 51'(sin_q * ry_q);
      end
      rbpm_pkg::ST_MB: begin
        nx_q <= pivot_x_q + rot_term + shift_x_q;
        p1_q <= 51'(sin_q * rx_q);
        p2_q <= 51'(cos_q * ry_q);
      end
      rbpm_pkg::ST_MC: begin
        ny_q <= pivot_y_q + rot_term + shift_y_q;
      end
      rbpm_pkg::ST_SPX, rbpm_pkg::ST_SPY: begin
        if (state_q == rbpm_pkg::ST_SPY) spx_q <= sp_val;
        hi_q  <= 49'(dmag[32:16]) * 49'(inv_dt_q);
        lo_q  <= 48'(dmag[15:0]) * 48'(inv_dt_q);
        neg_q <= dif[32];
      end
      rbpm_pkg::ST_SQ: begin
        spy_q <= sp_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbpm_pkg::ST_IDLE;
      inv_dt_q    <= 32'd65536;
      init_x_q    <= '0;
      init_y_q    <= '0;
      center_x_q  <= '0;
      center_y_q  <= '0;
      pivot_x_q   <= '0;
      pivot_y_q   <= '0;
      shift_x_q   <= '0;
      shift_y_q   <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_a_q    <= '0;
      cos_q       <= rbpm_pkg::ONE_Q16;
      sin_q       <= '0;
      motion_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rbpm_pkg::REG_INV_DT: inv_dt_q <= cfg_data_i;
          rbpm_pkg::REG_INIT_X: init_x_q <= $signed(cfg_data_i);
          rbpm_pkg::REG_INIT_Y: init_y_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      if (state_q == rbpm_pkg::ST_IDLE && head_i.valid && it.op == rbpm_pkg::ACT_PATH) begin
        if (it.first) begin
          center_x_q <= init_x_q;
          center_y_q <= init_y_q;
        end else begin
          shift_x_q  <= nshift_x;
          shift_y_q  <= nshift_y;
          pivot_x_q  <= center_x_q;
          pivot_y_q  <= center_y_q;
          center_x_q <= center_x_q + nshift_x;
          center_y_q <= center_y_q + nshift_y;
          motion_q   <= 1'b1;
        end
        last_x_q <= it.x;
        last_y_q <= it.y;
        last_a_q <= it.angle;
      end
      if (state_q == rbpm_pkg::ST_ROUND) begin
        cos_q <= flip_q ? 18'sd0 - x_rnd[17:0] : x_rnd[17:0];
        sin_q <= flip_q ? 18'sd0 - y_rnd[17:0] : y_rnd[17:0];
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      moved_index_o <= idx_q;
      moved_x_o     <= nx_q;
      moved_y_o     <= ny_q;
      speed_x_o     <= spx_q;
      speed_y_o     <= spy_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/rigid_body_point_mover_core.sv]
// Top level of the rigid body point mover: front end, queue and back end.
// An update request holds the back end through RD, MA, MB, MC, SPX, SPY, SQ and EMIT
// (shared two-multiplier datapath), waiting in EMIT until the output register is free;
// a load is done in the idle state. A trajectory request holds it through the iterative
// angle reduction, the fold, the one-step-per-cycle CORDIC unit and the rounding state.
// Active-low asynchronous reset clears queue, result and motion state, not the point store.
module rigid_body_point_mover_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         point_index_i,
  input  logic signed [31:0] load_x_i,
  input  logic signed [31:0] load_y_i,
  input  logic signed [31:0] path_x_i,
  input  logic signed [31:0] path_y_i,
  input  logic signed [31:0] path_angle_i,
  input  logic               first_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         moved_index_o,
  output logic signed [31:0] moved_x_o,
  output logic signed [31:0] moved_y_o,
  output logic signed [31:0] speed_x_o,
  output logic signed [31:0] speed_y_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  // The front end classifies each request and drops those that have no effect
  // (unused action code or an index beyond the point store).
  logic                  q_push, q_full, q_pop;
  rbpm_pkg::item_t       q_item;
  rbpm_pkg::queue_head_t q_head;

  rbpm_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .point_index_i  (point_index_i),
    .load_x_i       (load_x_i),
    .load_y_i       (load_y_i),
    .path_x_i       (path_x_i),
    .path_y_i       (path_y_i),
    .path_angle_i   (path_angle_i),
    .first_sample_i (first_sample_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_item)
  );

  // The queue lets the front end keep accepting while the back end is busy.
  rbpm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  // The back end executes one request at a time in order, and holds its result
  // in an output register so it can start on the next request meanwhile.
  rbpm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .moved_index_o (moved_index_o),
    .moved_x_o     (moved_x_o),
    .moved_y_o     (moved_y_o),
    .speed_x_o     (speed_x_o),
    .speed_y_o     (speed_y_o)
  );

endmodule

[hdl/rbpm_checker.sv]
// Port-level checks for the rigid body point mover, bound to the top level.
module rbpm_assert (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] moved_x_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(moved_x_o))
    else $error("result changed while stalled");

  // Reset drops any pending result.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // Reset empties the queue, so requests can be taken.
  assert property (@(posedge clk_i) !rst_ni |-> in_ready_o)
    else $error("not ready during reset");

endmodule

bind rigid_body_point_mover_core rbpm_assert u_rbpm_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .moved_x_o   (moved_x_o)
);

[dv/rbpm_checker.sv]
// Checker for the rigid body point mover: predicts every update result and compares it.
module rbpm_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         action_i,
  input  logic [7:0]         point_index_i,
  input  logic signed [31:0] load_x_i,
  input  logic signed [31:0] load_y_i,
  input  logic signed [31:0] path_x_i,
  input  logic signed [31:0] path_y_i,
  input  logic signed [31:0] path_angle_i,
  input  logic               first_sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [7:0]         moved_index_i,
  input  logic signed [31:0] moved_x_i,
  input  logic signed [31:0] moved_y_i,
  input  logic signed [31:0] speed_x_i,
  input  logic signed [31:0] speed_y_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output int                 err_cnt_o,
  output int                 pending_o,
  output int                 moves_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TURN   = 105414357;
  localparam longint HALF_T = 52707179;
  localparam longint QUART  = 26353589;
  localparam longint K_Q30  = 652032874;
  localparam longint ARCTAN [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct {
    logic [7:0]         index;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } move_t;

  move_t  moves_due[$];
  longint store_x [rbpm_pkg::NUM_POINTS];
  longint store_y [rbpm_pkg::NUM_POINTS];
  longint ctr_x, ctr_y, piv_x, piv_y, rot_c, rot_s, off_x, off_y;
  longint prev_x, prev_y, prev_a, start_x, start_y;
  longint unsigned rate;
  bit     armed;

  assign pending_o = moves_due.size();

  function automatic longint wrap(longint v);
    return longint'(signed'(v[31:0]));
  endfunction

  // Cosine and sine of the angle step, Q2.16, from a fixed-gain CORDIC rotation.
  function automatic void turn_by(longint d);
    longint r, x, y, xs, ys;
    bit     flip;
    r = d % TURN;
    x = K_Q30;
    y = 0;
    flip = 1'b0;
    if (r > HALF_T) r -= TURN;
    if (r < -HALF_T) r += TURN;
    if (r > QUART) begin
      r -= HALF_T;
      flip = 1'b1;
    end else if (r < -QUART) begin
      r += HALF_T;
      flip = 1'b1;
    end
    for (int i = 0; i < rbpm_pkg::CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (r >= 0) begin
        x -= ys; y += xs; r -= ARCTAN[i];
      end else begin
        x += ys; y -= xs; r += ARCTAN[i];
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    rot_c = flip ? -x : x;
    rot_s = flip ? -y : y;
  endfunction

  // Displacement times 1/dt, rounded half away from zero, saturated.
  function automatic logic signed [31:0] velocity(longint d);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = (mag >> 16) * rate + ((((mag & 64'hFFFF) * rate) + 64'h8000) >> 16);
    if (d < 0) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-longint'(q));
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
  endfunction

  function automatic void accept_request();
    longint ox, oy, rx, ry, nx, ny;
    move_t  m;
    case (action_i)
      rbpm_pkg::ACT_LOAD: begin
        store_x[point_index_i] = longint'(load_x_i);
        store_y[point_index_i] = longint'(load_y_i);
      end
      rbpm_pkg::ACT_PATH: begin
        if (first_sample_i) begin
          ctr_x = start_x;
          ctr_y = start_y;
        end else begin
          off_x = wrap(longint'(path_x_i) - prev_x);
          off_y = wrap(longint'(path_y_i) - prev_y);
          turn_by(longint'(path_angle_i) - prev_a);
          piv_x = ctr_x;
          piv_y = ctr_y;
          ctr_x = wrap(ctr_x + off_x);
          ctr_y = wrap(ctr_y + off_y);
          armed = 1'b1;
        end
        prev_x = longint'(path_x_i);
        prev_y = longint'(path_y_i);
        prev_a = longint'(path_angle_i);
      end
      rbpm_pkg::ACT_MOVE: begin
        if (armed) begin
          ox = store_x[point_index_i];
          oy = store_y[point_index_i];
          rx = ox - piv_x;
          ry = oy - piv_y;
          nx = wrap(piv_x + ((rot_c * rx - rot_s * ry + 32768) >>> 16) + off_x);
          ny = wrap(piv_y + ((rot_s * rx + rot_c * ry + 32768) >>> 16) + off_y);
          store_x[point_index_i] = nx;
          store_y[point_index_i] = ny;
          m.index = point_index_i;
          m.x = 32'(nx);
          m.y = 32'(ny);
          m.vx = velocity(nx - ox);
          m.vy = velocity(ny - oy);
          moves_due.push_back(m);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt_o++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    move_t m;
    if (!rst_ni) begin
      moves_due.delete();
      ctr_x = 0; ctr_y = 0; piv_x = 0; piv_y = 0;
      rot_c = 65536; rot_s = 0; off_x = 0; off_y = 0;
      prev_x = 0; prev_y = 0; prev_a = 0;
      start_x = 0; start_y = 0;
      rate = 65536;
      armed = 1'b0;
      err_cnt_o = 0;
      moves_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rbpm_pkg::REG_INV_DT: rate = 64'(cfg_data_i);
          rbpm_pkg::REG_INIT_X: start_x = longint'(signed'(cfg_data_i));
          rbpm_pkg::REG_INIT_Y: start_y = longint'(signed'(cfg_data_i));
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) accept_request();
      if (out_valid_i && out_ready_i) begin
        moves_seen_o++;
        if (moves_due.size() == 0) begin
          err_cnt_o++;
          $display("%0t: unexpected result, index %0d x %0h y %0h", $realtime,
                   moved_index_i, moved_x_i, moved_y_i);
        end else begin
          m = moves_due.pop_front();
          compare_field("moved_index", 32'(m.index), 32'(moved_index_i));
          compare_field("moved_x", m.x, moved_x_i);
          compare_field("moved_y", m.y, moved_y_i);
          compare_field("speed_x", m.vx, speed_x_i);
          compare_field("speed_y", m.vy, speed_y_i);
        end
      end
    end
  end

endmodule

[dv/tb_top.sv]
// Testbench top of the rigid body point mover: stimulus, stalls, watchdog and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One request on the input channel, every port field of its own.
  typedef struct {
    logic [1:0]         act;
    logic [7:0]         idx;
    logic signed [31:0] lx, ly, px, py, pa;
    logic               first;
  } req_t;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 100;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [1:0] action_i;
  logic [7:0] point_index_i;
  logic signed [31:0] load_x_i, load_y_i, path_x_i, path_y_i, path_angle_i;
  logic first_sample_i;
  logic out_valid_o, out_ready_i;
  logic [7:0] moved_index_o;
  logic signed [31:0] moved_x_o, moved_y_o, speed_x_o, speed_y_o;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  int err_cnt, pending, moves_seen, idle_cycles;
  int n_load, n_path, n_move, n_noise;
  bit calm;           // when set, neither side inserts gaps
  bit loaded [256];   // points that hold a defined value
  logic signed [31:0] last_angle;

  rigid_body_point_mover_core dut (.*);

  rbpm_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .point_index_i,
    .load_x_i, .load_y_i, .path_x_i, .path_y_i, .path_angle_i, .first_sample_i,
    .out_valid_i(out_valid_o), .out_ready_i, .moved_index_i(moved_index_o),
    .moved_x_i(moved_x_o), .moved_y_i(moved_y_o), .speed_x_i(speed_x_o),
    .speed_y_i(speed_y_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .err_cnt_o(err_cnt), .pending_o(pending), .moves_seen_o(moves_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Draws the stall or gap before the next transfer; none at all in calm phases.
  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Result side: after each accepted result, drop ready for a random number of cycles.
  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Watchdog: any cycle without traffic on a channel or the register port counts.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // A request with every field random, so unused fields toggle as well.
  function automatic req_t any_req();
    req_t r;
    r.act = 2'($urandom_range(0, 3));
    r.idx = 8'($urandom);
    r.lx = $urandom; r.ly = $urandom;
    r.px = $urandom; r.py = $urandom; r.pa = $urandom;
    r.first = 1'($urandom);
    return r;
  endfunction

  // Q16.16 coordinate: mostly moderate, sometimes over the full range.
  function automatic logic signed [31:0] coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
  endfunction

  task automatic send(req_t r);
    int n;
    n = draw_gap();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= r.act;
    point_index_i  <= r.idx;
    load_x_i       <= r.lx;
    load_y_i       <= r.ly;
    path_x_i       <= r.px;
    path_y_i       <= r.py;
    path_angle_i   <= r.pa;
    first_sample_i <= r.first;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    case (r.act)
      rbpm_pkg::ACT_LOAD: begin
        loaded[r.idx] = 1'b1;
        n_load++;
      end
      rbpm_pkg::ACT_PATH: begin
        last_angle = r.pa;
        n_path++;
      end
      rbpm_pkg::ACT_MOVE: n_move++;
      default:  n_noise++;
    endcase
  endtask

  task automatic load_point(logic [7:0] idx, logic signed [31:0] x, logic signed [31:0] y);
    req_t r;
    r = any_req();
    r.act = rbpm_pkg::ACT_LOAD; r.idx = idx; r.lx = x; r.ly = y;
    send(r);
  endtask

  task automatic path_sample(logic f, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] a);
    req_t r;
    r = any_req();
    r.act = rbpm_pkg::ACT_PATH; r.first = f; r.px = x; r.py = y; r.pa = a;
    send(r);
  endtask

  task automatic move_point(logic [7:0] idx);
    req_t r;
    r = any_req();
    r.act = rbpm_pkg::ACT_MOVE; r.idx = idx;
    send(r);
  endtask

  // Registers change only with the block idle: every result in, and time for
  // queued trajectory requests, which give no result, to finish their CORDIC pass.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] rate, logic [31:0] cx, logic [31:0] cy);
    cfg_we_i <= 1'b1; cfg_idx_i <= rbpm_pkg::REG_INV_DT; cfg_data_i <= rate;
    @(posedge clk_i);
    cfg_idx_i <= rbpm_pkg::REG_INIT_X; cfg_data_i <= cx;
    @(posedge clk_i);
    cfg_idx_i <= rbpm_pkg::REG_INIT_Y; cfg_data_i <= cy;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A well-formed motion: first sample, a few loads, then samples and updates mixed
  // with reloads, stray first samples and unused actions.
  task automatic motion_phase(int count);
    req_t r;
    int   k, pick;
    path_sample(1'b1, coord(), coord(), $urandom);
    repeat (6) load_point(8'($urandom_range(0, 255)), coord(), coord());
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        if ($urandom_range(0, 4) == 0) r.pa = $urandom;
        else r.pa = last_angle + $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        path_sample(1'b0, coord(), coord(), r.pa);
      end else if (pick < 26) begin
        load_point(8'($urandom), coord(), coord());
      end else if (pick < 92) begin
        r.idx = 8'($urandom);
        while (!loaded[r.idx]) r.idx = 8'($urandom);
        move_point(r.idx);
      end else if (pick < 96) begin
        r = any_req();
        r.act = rbpm_pkg::ACT_SPARE;
        send(r);
      end else begin
        path_sample(1'b1, coord(), coord(), $urandom);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = '0; point_index_i = '0;
    load_x_i = '0; load_y_i = '0; path_x_i = '0; path_y_i = '0; path_angle_i = '0;
    first_sample_i = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    calm = 1'b0;
    last_angle = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the largest rate, so that extreme moves saturate the speed.
    write_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    load_point(8'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    load_point(8'd255, 32'sh8000_0000, 32'sh7FFF_FFFF);
    load_point(8'd1, 32'sh0, 32'shFFFF_FFFF);
    move_point(8'd0);                    // nothing latched yet: no result
    begin
      req_t r;
      r = any_req();
      r.act = rbpm_pkg::ACT_SPARE;
      send(r);                           // unused action is dropped
    end
    path_sample(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    move_point(8'd255);                  // first sample alone does not arm updates
    path_sample(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    move_point(8'd0);
    move_point(8'd255);
    move_point(8'd1);
    path_sample(1'b0, 32'sh0, 32'sh0, 32'sh7FFF_FFFF); // no turn at all
    move_point(8'd0);
    path_sample(1'b0, 32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_FFFF + 32'sd40000000);
    move_point(8'd1);                    // more than a quarter turn: folded
    path_sample(1'b0, 32'sh0, 32'sh0, 32'sh7FFF_FFFF - 32'sd45000000);
    move_point(8'd255);
    path_sample(1'b0, 32'sh0, 32'sh0, 32'sh7FFF_FFFF - 32'sd45000000 - 32'sd52707179);
    move_point(8'd0);
    drain();

    // Random phases over several register settings, the extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_regs(32'd65536, 32'h0, 32'h0);
        1: write_regs(32'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        2: write_regs(32'hFFFF_FFFF, $urandom, $urandom);
        default: write_regs($urandom_range(1, 32'h0010_0000), coord(), coord());
      endcase
      calm = (ph == 3);
      motion_phase(100);
      drain();
    end

    repeat (SETTLE) @(posedge clk_i);
    $display("Sent %0d loads, %0d trajectory samples, %0d updates, %0d unused actions.",
             n_load, n_path, n_move, n_noise);
    $display("Checked %0d moved points over seven register settings.", moves_seen);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/rbpm_pkg.sv
hdl/rbpm_front.sv
hdl/rbpm_queue.sv
hdl/rbpm_back.sv
hdl/rigid_body_point_mover_core.sv
hdl/rbpm_checker.sv
dv/rbpm_checker.sv
dv/tb_top.sv
